// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SPMQ_ASSERT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("spmq assertion failed");
`define SPMQ_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("spmq assertion failed");
`else
`define SPMQ_ASSERT(label, clk, rst, pre, post)
`define SPMQ_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ----- hw/rtl/spmq_pkg.sv -----
package spmq_pkg;

  localparam int PRIO_W   = 8;
  localparam int TAG_W    = 16;
  localparam int LEVEL_W  = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 3;

  localparam int LEVELS_DEFAULT      = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int TAG_WIDTH_DEFAULT   = 16;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // served_level code for the urgent FIFO (-1)
  localparam logic signed [LEVEL_W-1:0] URGENT_LEVEL = 4'sb1111;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_DROP  = 2'd1,
    ST_POP   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // queue choice for one transaction
  typedef struct packed {
    logic       urgent;
    logic [2:0] level;
    logic       none;
  } sel_t;

endpackage

// ----- hw/rtl/spmq_ifs.sv -----
interface spmq_cmd_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [spmq_pkg::PRIO_W-1:0] priority_req;
  logic [spmq_pkg::TAG_W-1:0]         task_tag;

  modport source(output valid, mode, priority_req, task_tag, input ready);
  modport sink(input valid, mode, priority_req, task_tag, output ready);
endinterface

interface spmq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [spmq_pkg::STATUS_W-1:0]       status;
  logic [spmq_pkg::TAG_W-1:0]          out_tag;
  logic signed [spmq_pkg::LEVEL_W-1:0] served_level;

  modport source(output valid, status, out_tag, served_level, input ready);
  modport sink(input valid, status, out_tag, served_level, output ready);
endinterface

// ----- hw/rtl/strict_priority_multi_queue_top.sv -----
// Strict priority multi-queue: one urgent FIFO plus LEVELS ordinary FIFOs.
// Sequence: pointer RAM read (S_PTR), tag RAM read on a pop (S_TAG), output register load (S_OUT).
// A new transaction is accepted only in S_IDLE, after the previous result is loaded into the output
// register; a stall on rsp.ready holds the sequencer in S_OUT.
// Reset (rst, synchronous, active high): all queues empty, max_priority 0,
// no clearing pass; per-queue valid bits make unwritten pointers read as zero.
`include "assert_macros.svh"

module strict_priority_multi_queue_top #(
  parameter int LEVELS      = spmq_pkg::LEVELS_DEFAULT,
  parameter int QUEUE_DEPTH = spmq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int TAG_WIDTH   = spmq_pkg::TAG_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [spmq_pkg::CFG_W-1:0] cfg_wdata,
  spmq_cmd_if.sink                   cmd,
  spmq_rsp_if.source                 rsp
);

  // Queue numbering: levels 0..LEVELS-1, urgent FIFO is queue LEVELS.
  localparam int NQ  = LEVELS + 1;
  localparam int QW  = $clog2(NQ);
  localparam int SLW = $clog2(QUEUE_DEPTH);          // slot index
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);      // occupancy count
  localparam int PW  = SLW + CW;                     // pointer word {head, count}
  localparam int NT  = NQ * QUEUE_DEPTH;             // tag RAM entries
  localparam int AW  = $clog2(NT);
  // stored tag width; the port field is only TAG_W bits wide
  localparam int SW  = (TAG_WIDTH < spmq_pkg::TAG_W) ? TAG_WIDTH : spmq_pkg::TAG_W;
  localparam logic [QW-1:0] URGENT_Q = QW'(LEVELS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,    // pointer word available: decide, update pointers, write or read tag
    S_TAG,    // popped tag available
    S_OUT     // hand result to the output register
  } state_t;

  state_t                      state;
  logic [spmq_pkg::CFG_W-1:0]  max_priority;
  logic [LEVELS:0]             nonempty;     // occupancy flags, flip-flops
  logic [LEVELS:0]             ptr_valid;    // pointer RAM entry written since reset

  // transaction under work
  logic                        req_mode;
  spmq_pkg::sel_t              req_sel;
  logic [QW-1:0]               qid;
  logic [SW-1:0]               tag;
  logic                        ptr_vld_q;

  // pending result
  spmq_pkg::status_t                   res_status;
  logic [spmq_pkg::TAG_W-1:0]          res_tag;
  logic signed [spmq_pkg::LEVEL_W-1:0] res_level;

  // output register
  logic                                out_valid;
  spmq_pkg::status_t                   out_status;
  logic [spmq_pkg::TAG_W-1:0]          out_tag;
  logic signed [spmq_pkg::LEVEL_W-1:0] out_level;

  spmq_pkg::sel_t sel;
  logic [QW-1:0]  sel_qid;
  logic           accept;

  logic [PW-1:0]  ptr_rdata;
  logic [PW-1:0]  ptr_wdata;
  logic           ptr_we;
  logic [SLW-1:0] cur_head;
  logic [CW-1:0]  cur_count;
  logic [SLW-1:0] head_inc;
  logic [SLW:0]   tail_sum;
  logic [SLW-1:0] tail;
  logic           full;
  logic           push_ok;
  logic           do_pop;
  logic [AW-1:0]  base;
  logic           tag_we;
  logic           tag_re;
  logic [AW-1:0]  tag_waddr;
  logic [AW-1:0]  tag_raddr;
  logic [SW-1:0]  tag_rdata;

  // ---------------------------------------------------------------------------
  // Queue choice, made on the incoming transaction
  // ---------------------------------------------------------------------------
  spmq_select #(.LEVELS(LEVELS)) u_select (
    .mode         (cmd.mode),
    .priority_req (cmd.priority_req),
    .max_priority (max_priority),
    .nonempty     (nonempty),
    .sel          (sel)
  );

  assign sel_qid   = sel.urgent ? URGENT_Q : QW'(sel.level);
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // ---------------------------------------------------------------------------
  // Pointer RAM: one {head, count} word per queue, read on accept
  // ---------------------------------------------------------------------------
  spmq_ram #(.DEPTH(NQ), .WIDTH(PW)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (qid),
    .wdata (ptr_wdata),
    .re    (accept),
    .raddr (sel_qid),
    .rdata (ptr_rdata)
  );

  // never-written entry reads as an empty queue
  assign cur_head  = ptr_vld_q ? ptr_rdata[PW-1:CW] : '0;
  assign cur_count = ptr_vld_q ? ptr_rdata[CW-1:0]  : '0;

  assign full     = (cur_count == CW'(QUEUE_DEPTH));
  assign head_inc = (cur_head == SLW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  // head + count wraps at most once
  assign tail_sum = (SLW + 1)'(cur_head) + (SLW + 1)'(cur_count);
  assign tail     = (tail_sum >= (SLW + 1)'(QUEUE_DEPTH))
                    ? SLW'(tail_sum - (SLW + 1)'(QUEUE_DEPTH)) : SLW'(tail_sum);

  assign push_ok = (req_mode == spmq_pkg::MODE_ENQ) && !full;
  assign do_pop  = (req_mode == spmq_pkg::MODE_DEQ) && !req_sel.none;

  assign ptr_we    = (state == S_PTR) && (push_ok || do_pop);
  assign ptr_wdata = push_ok ? {cur_head, cur_count + 1'b1} : {head_inc, cur_count - 1'b1};

  // ---------------------------------------------------------------------------
  // Tag RAM: queue-major layout, QUEUE_DEPTH slots per queue
  // ---------------------------------------------------------------------------
  assign base      = AW'(qid) * AW'(QUEUE_DEPTH);
  assign tag_we    = (state == S_PTR) && push_ok;
  assign tag_re    = (state == S_PTR) && do_pop;
  assign tag_waddr = base + AW'(tail);
  assign tag_raddr = base + AW'(cur_head);

  spmq_ram #(.DEPTH(NT), .WIDTH(SW)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer, flags and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_priority <= '0;
      nonempty     <= '0;
      ptr_valid    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_priority <= cfg_wdata;
      end
      // load wins over the drain of the previous result
      if (state == S_OUT && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_mode  <= cmd.mode;
            req_sel   <= sel;
            qid       <= sel_qid;
            tag       <= cmd.task_tag[SW-1:0];
            ptr_vld_q <= ptr_valid[sel_qid];
            state     <= S_PTR;
          end
        end
        S_PTR: begin
          res_tag <= '0;
          if (req_sel.none) begin
            res_level <= '0;
          end else if (req_sel.urgent) begin
            res_level <= spmq_pkg::URGENT_LEVEL;
          end else begin
            res_level <= $signed({1'b0, req_sel.level});
          end
          if (req_mode == spmq_pkg::MODE_ENQ) begin
            res_status <= full ? spmq_pkg::ST_DROP : spmq_pkg::ST_ENQ;
            if (!full) begin
              nonempty[qid]  <= 1'b1;
              ptr_valid[qid] <= 1'b1;
            end
            state <= S_OUT;
          end else if (req_sel.none) begin
            res_status <= spmq_pkg::ST_EMPTY;
            state      <= S_OUT;
          end else begin
            res_status     <= spmq_pkg::ST_POP;
            nonempty[qid]  <= (cur_count != CW'(1));
            ptr_valid[qid] <= 1'b1;
            state          <= S_TAG;
          end
        end
        S_TAG: begin
          res_tag <= spmq_pkg::TAG_W'(tag_rdata);
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_status <= res_status;
            out_tag    <= res_tag;
            out_level  <= res_level;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_tag      = out_tag;
  assign rsp.served_level = out_level;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SPMQ_ASSERT_NEXT(a_accept_to_ptr, clk, rst, accept, state == S_PTR)
  `SPMQ_ASSERT(a_pop_has_data, clk, rst, state == S_PTR && do_pop, cur_count != '0)
  `SPMQ_ASSERT(a_count_bound, clk, rst, state == S_PTR, cur_count <= CW'(QUEUE_DEPTH))
  `SPMQ_ASSERT_NEXT(a_urgent_first, clk, rst, accept && cmd.mode == spmq_pkg::MODE_DEQ && nonempty[URGENT_Q], req_sel.urgent)

endmodule

// ----- hw/rtl/spmq_ram.sv -----
module spmq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/spmq_select.sv -----
module spmq_select #(
  parameter int LEVELS = spmq_pkg::LEVELS_DEFAULT
) (
  input  logic                               mode,
  input  logic signed [spmq_pkg::PRIO_W-1:0] priority_req,
  input  logic [spmq_pkg::CFG_W-1:0]         max_priority,
  input  logic [LEVELS:0]                    nonempty,     // [LEVELS] is urgent
  output spmq_pkg::sel_t                     sel
);

  localparam int TOP_CAP = (LEVELS - 1 < 7) ? LEVELS - 1 : 7;
  localparam logic [spmq_pkg::CFG_W-1:0] TOP_CAP_V = spmq_pkg::CFG_W'(TOP_CAP);

  logic [spmq_pkg::CFG_W-1:0] top;

  assign top = (max_priority > TOP_CAP_V) ? TOP_CAP_V : max_priority;

  always_comb begin
    logic       found;
    logic [2:0] lvl;
    found = 1'b0;
    lvl   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (nonempty[i] && i <= int'(top)) begin
        found = 1'b1;
        lvl   = 3'(i);
      end
    end
    sel = '0;
    if (mode == spmq_pkg::MODE_ENQ) begin
      sel.urgent = priority_req[spmq_pkg::PRIO_W-1];
      // clamp to the active top level
      if (priority_req[spmq_pkg::PRIO_W-2:0] > (spmq_pkg::PRIO_W-1)'(top)) begin
        sel.level = top;
      end else begin
        sel.level = priority_req[2:0];
      end
    end else begin
      sel.urgent = nonempty[LEVELS];
      sel.level  = lvl;
      sel.none   = !nonempty[LEVELS] && !found;
    end
  end

endmodule

// ----- dv/strict_priority_multi_queue_top_tb.sv -----
module strict_priority_multi_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spmq_pkg::*;

  localparam int LEVELS      = LEVELS_DEFAULT;
  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT;
  // Overall run limit, in clock cycles.
  localparam int CYCLE_LIMIT = 400000;

  // One command transaction as the sender presents it.
  typedef struct {
    logic               mode;
    logic signed [7:0]  prio;
    logic [TAG_W-1:0]   tag;
  } sched_cmd_t;

  // One response transaction as the scheduler should return it.
  typedef struct {
    status_t                   status;
    logic [TAG_W-1:0]          out_tag;
    logic signed [LEVEL_W-1:0] served_level;
  } sched_rsp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  spmq_cmd_if cmd_ch();
  spmq_rsp_if rsp_ch();

  strict_priority_multi_queue_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch.sink),
    .rsp       (rsp_ch.source)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: one urgent FIFO plus one FIFO per level, bounded at
  // QUEUE_DEPTH, and the active top level as last written.
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0] urgent_tags[$];
  logic [TAG_W-1:0] level_tags[LEVELS][$];
  int               top_level = 0;

  sched_cmd_t cmds_to_send[$];  // queued by the stimulus, drained by the driver
  sched_rsp_t rsp_due[$];       // responses owed by the scheduler, oldest first

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  no_idle     = 1'b0;      // set for the closing stretch: no gaps, no stalls
  bit  cmd_held    = 1'b0;      // driver is presenting a transaction

  // Applies one accepted command to the shadow queues and returns the response
  // the scheduler owes for it.
  function automatic sched_rsp_t serve_cmd(sched_cmd_t c);
    sched_rsp_t r;
    int         lvl;
    r.status       = ST_EMPTY;
    r.out_tag      = '0;
    r.served_level = '0;
    if (c.mode == MODE_ENQ) begin
      if (c.prio < 0) begin
        r.served_level = URGENT_LEVEL;
        if (urgent_tags.size() < QUEUE_DEPTH) begin
          urgent_tags.push_back(c.tag);
          r.status = ST_ENQ;
        end else begin
          r.status = ST_DROP;
        end
      end else begin
        // requests above the active top clamp down to it
        lvl = (int'(c.prio) > top_level) ? top_level : int'(c.prio);
        r.served_level = LEVEL_W'(lvl);
        if (level_tags[lvl].size() < QUEUE_DEPTH) begin
          level_tags[lvl].push_back(c.tag);
          r.status = ST_ENQ;
        end else begin
          r.status = ST_DROP;
        end
      end
    end else begin
      if (urgent_tags.size() != 0) begin
        r.status       = ST_POP;
        r.out_tag      = urgent_tags.pop_front();
        r.served_level = URGENT_LEVEL;
      end else begin
        // highest active level first; levels above the top stay untouched
        for (int i = top_level; i >= 0; i--) begin
          if (r.status == ST_EMPTY && level_tags[i].size() != 0) begin
            r.status       = ST_POP;
            r.out_tag      = level_tags[i].pop_front();
            r.served_level = LEVEL_W'(i);
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got,
             want);
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: presents queued transactions, holds each until accepted,
  // inserts idle bursts at random.
  // ---------------------------------------------------------------------------
  sched_cmd_t cur_cmd;
  int         send_gap = 0;

  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_held = 1'b0;
    end else begin
      busy = cmd_held;
      if (cmd_ch.valid && cmd_ch.ready) begin
        // accepted: the response is predicted right here
        rsp_due.push_back(serve_cmd(cur_cmd));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmds_to_send.size() != 0) begin
          if (!no_idle && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 18);
          end else begin
            cur_cmd = cmds_to_send.pop_front();
            busy    = 1'b1;
          end
        end
      end
      cmd_held = busy;
      cmd_ch.valid <= busy;
      if (busy) begin
        cmd_ch.mode         <= cur_cmd.mode;
        cmd_ch.priority_req <= cur_cmd.prio;
        cmd_ch.task_tag     <= cur_cmd.tag;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: random stall bursts on ready, field-by-field compare
  // against the oldest owed response.
  // ---------------------------------------------------------------------------
  int recv_gap = 0;

  always @(posedge clk) begin
    sched_rsp_t want;
    bit         rdy;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("unexpected response, status", int'(rsp_ch.status), -1);
        end else begin
          want = rsp_due.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", int'(rsp_ch.status), int'(want.status));
          if (rsp_ch.out_tag !== want.out_tag)
            report_mismatch("out_tag", int'(rsp_ch.out_tag), int'(want.out_tag));
          if (rsp_ch.served_level !== want.served_level)
            report_mismatch("served_level", int'(rsp_ch.served_level),
                            int'(want.served_level));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 18);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_ch.ready <= rdy;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_cmd(logic mode, logic signed [7:0] prio, logic [TAG_W-1:0] tag);
    sched_cmd_t c;
    c.mode = mode;
    c.prio = prio;
    c.tag  = tag;
    cmds_to_send.push_back(c);
  endfunction

  // Priority mix: urgent, in-range levels, above-top requests, anything.
  function automatic logic signed [7:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2)
      return 8'($urandom_range(128, 255));
    else if (r == 2)
      return 8'($urandom_range(0, 255));
    else if (r == 3)
      return 8'($urandom_range(8, 127));
    return 8'($urandom_range(0, LEVELS - 1));
  endfunction

  // Runs of same-mode transactions so queues actually fill and drain;
  // enq_pct sets the share of enqueue runs.
  task automatic queue_traffic(int n, int enq_pct);
    int   left;
    int   run;
    logic mode;
    left = n;
    while (left > 0) begin
      mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      run  = $urandom_range(1, 20);
      if (run > left)
        run = left;
      // dequeues carry random priority and tag too; the scheduler ignores them
      repeat (run) add_cmd(mode, pick_prio(), TAG_W'($urandom));
      left -= run;
    end
  endtask

  // Sender pauses until every owed response is back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (cmds_to_send.size() != 0 || cmd_held || rsp_due.size() != 0);
  endtask

  // Register write; only called while nothing is in flight.
  task automatic set_top_level(int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    top_level = (v > LEVELS - 1) ? LEVELS - 1 : v;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_ch.valid        = 1'b0;
    cmd_ch.mode         = MODE_ENQ;
    cmd_ch.priority_req = '0;
    cmd_ch.task_tag     = '0;
    rsp_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, top level 0 from reset: empty dequeue, field extremes,
    // clamp of a high request, urgent served ahead of level 0.
    add_cmd(MODE_DEQ, 8'sd0, 16'h0000);
    add_cmd(MODE_ENQ, -8'sd128, 16'hFFFF);
    add_cmd(MODE_ENQ, 8'sd127, 16'h0000);
    add_cmd(MODE_ENQ, 8'sd0, 16'hA5A5);
    add_cmd(MODE_ENQ, -8'sd1, 16'h5A5A);
    repeat (4) add_cmd(MODE_DEQ, 8'sd0, 16'h0000);
    add_cmd(MODE_DEQ, -8'sd1, 16'hFFFF);
    wait_quiet();

    // Directed, top level 7: ordering across levels, clamp to 7.
    set_top_level(7);
    add_cmd(MODE_ENQ, 8'sd7, 16'h1234);
    add_cmd(MODE_ENQ, 8'sd3, 16'h8001);
    add_cmd(MODE_ENQ, 8'sd100, 16'h7FFE);
    add_cmd(MODE_ENQ, 8'sd1, 16'h0001);
    add_cmd(MODE_ENQ, -8'sd64, 16'h0002);
    repeat (6) add_cmd(MODE_DEQ, 8'sd5, 16'hC3C3);
    wait_quiet();

    // Enqueue-heavy at full range: queues fill and drops appear.
    queue_traffic(200, 75);
    wait_quiet();

    // Lower the top while upper levels still hold tags: those must be skipped.
    set_top_level(2);
    queue_traffic(150, 30);
    wait_quiet();

    // Raise it again: the parked tags come back out.
    set_top_level(7);
    queue_traffic(150, 20);
    wait_quiet();

    // Only urgent and level 0 in use: both overflow quickly.
    set_top_level(0);
    queue_traffic(200, 70);
    wait_quiet();

    repeat (6) begin
      set_top_level($urandom_range(0, LEVELS - 1));
      queue_traffic(120, $urandom_range(30, 70));
      wait_quiet();
    end

    // Closing stretch at full rate on both sides.
    set_top_level(5);
    no_idle = 1'b1;
    queue_traffic(200, 50);
    wait_quiet();

    // Let any stray response show up before the verdict.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
